// ===== rtl/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/iso_pkg.sv =====
package iso_pkg;

   localparam int MAX_ITEMS  = 64;
   localparam int DATA_WIDTH = 32;
   localparam int CNT_W      = $clog2(MAX_ITEMS + 1);

   typedef logic [DATA_WIDTH-1:0] data_type;
   typedef logic [CNT_W-1:0]      count_type;

   typedef enum logic {
      ST_COLLECT,
      ST_EMIT
   } state_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic     insert;
      logic     shift_out;
      data_type value;
   } cell_ctrl_type;

   // Handed from each cell to its right neighbor.
   typedef struct packed {
      data_type value;
      logic     gt;
      logic     occ;
   } link_type;

endpackage

// ===== rtl/insertion_sorter.sv =====
// Collect: one beat per cycle, each stored value placed in its cell in the cycle it is taken.
// The chain of MAX_ITEMS compare-and-shift cells sets this; req_tready is low while emitting.
// Emit: first result in the cycle after the last beat, then one result per cycle that
// rsp_tready allows, N results for a set of N stored values; next set starts after the final.
// Reset clears the controller state, the fill count and the overflow flag; cell contents
// are left as they are and are never read before written.
module insertion_sorter (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  iso_pkg::data_type         req_tdata,  // [31:0] value
   input  logic                      req_tlast,  // last
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output iso_pkg::data_type         rsp_tdata,  // [31:0] value_res
   output logic                      rsp_tlast,  // last_res
   output logic                      rsp_tuser   // [0] overflow
);
   import iso_pkg::*;

   cell_ctrl_type cell_ctrl;
   count_type     count;
   link_type      link [MAX_ITEMS+1];
   logic          occ  [MAX_ITEMS];

   iso_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_value    (req_tdata),
      .req_last     (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_last     (rsp_tlast),
      .rsp_overflow (rsp_tuser),
      .count        (count),
      .cell_ctrl    (cell_ctrl)
   );

   // the head of the chain sees an occupied, never-greater neighbor
   assign link[0] = '{value: '0, gt: 1'b0, occ: 1'b1};

   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      localparam count_type IDX = CNT_W'(i);
      localparam int        RIGHT = (i + 2 > MAX_ITEMS) ? MAX_ITEMS : i + 2;

      assign occ[i] = (IDX < count);

      iso_cell u_cell (
         .clock       (clock),
         .cell_ctrl   (cell_ctrl),
         .occ         (occ[i]),
         .left        (link[i]),
         .right_value (link[RIGHT].value),
         .right       (link[i+1])
      );
   end

   assign rsp_tdata = link[1].value;

endmodule

// ===== rtl/iso_cell.sv =====
module iso_cell (
   input  logic                  clock,
   input  iso_pkg::cell_ctrl_type cell_ctrl,
   input  logic                  occ,
   input  iso_pkg::link_type     left,
   input  iso_pkg::data_type     right_value,
   output iso_pkg::link_type     right
);
   import iso_pkg::*;

   data_type value_ff;
   data_type value_in;
   logic     gt;

   assign gt = occ && ($signed(value_ff) > $signed(cell_ctrl.value));

   always_comb begin
      value_in = value_ff;
      if (cell_ctrl.insert) begin
         // shift right where the left neighbor moves up, take the new value at the slot
         if (left.gt) begin
            value_in = left.value;
         end else if (gt || (!occ && left.occ)) begin
            value_in = cell_ctrl.value;
         end
      end else if (cell_ctrl.shift_out) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign right = '{value: value_ff, gt: gt, occ: occ};

endmodule

// ===== rtl/iso_ctrl.sv =====
module iso_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  iso_pkg::data_type      req_value,
   input  logic                   req_last,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic                   rsp_last,
   output logic                   rsp_overflow,
   output iso_pkg::count_type     count,
   output iso_pkg::cell_ctrl_type cell_ctrl
);
   import iso_pkg::*;

   state_type state_ff, state_in;
   count_type count_ff, count_in;
   logic      dropped_ff, dropped_in;
   logic      req_beat, rsp_beat, full, final_res;

   assign full      = (count_ff == CNT_W'(MAX_ITEMS));
   assign final_res = (count_ff == CNT_W'(1));
   assign req_beat  = req_tvalid && req_tready;
   assign rsp_beat  = rsp_tvalid && rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_COLLECT: if (req_beat && req_last) state_in = ST_EMIT;
         ST_EMIT:    if (rsp_beat && final_res) state_in = ST_COLLECT;
         default:    state_in = ST_COLLECT;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      cell_ctrl  = '{insert: 1'b0, shift_out: 1'b0, value: req_value};
      count_in   = count_ff;
      dropped_in = dropped_ff;
      unique case (state_ff)
         ST_COLLECT: begin
            req_tready = 1'b1;
            if (req_beat) begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  cell_ctrl.insert = 1'b1;
                  count_in         = count_ff + CNT_W'(1);
               end
            end
         end
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_beat) begin
               cell_ctrl.shift_out = 1'b1;
               count_in            = count_ff - CNT_W'(1);
               if (final_res) dropped_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_COLLECT;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   assign rsp_last     = final_res;
   assign rsp_overflow = dropped_ff;
   assign count        = count_ff;

endmodule

// ===== rtl/iso_checker.sv =====
`include "assert_macros.svh"

module iso_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic              req_tlast,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input iso_pkg::data_type rsp_tdata,
   input logic              rsp_tlast,
   input logic              rsp_tuser
);
   import iso_pkg::*;

   logic req_beat, rsp_beat;
   assign req_beat = req_tvalid && req_tready;
   assign rsp_beat = rsp_tvalid && rsp_tready;

   `ASSERT_CLK(a_no_overlap, clock, reset, !(req_tready && rsp_tvalid),
      "input taken during emit")
   `ASSERT_CLK(a_emit_start, clock, reset, (req_beat && req_tlast) |=> rsp_tvalid,
      "no result after last beat")
   `ASSERT_CLK(a_ascending, clock, reset,
      (rsp_beat && !rsp_tlast) |=> (rsp_tvalid && $stable(rsp_tuser)
         && ($signed(rsp_tdata) >= $signed($past(rsp_tdata)))),
      "results out of order")
   `ASSERT_CLK(a_set_done, clock, reset, (rsp_beat && rsp_tlast) |=> !rsp_tvalid,
      "result after final beat")
   `ASSERT_CLK(a_rsp_hold, clock, reset,
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast)),
      "stalled result changed")

endmodule

bind insertion_sorter iso_checker u_iso_checker (.*);

// ===== tb/sv/insertion_sorter_tb.sv =====
module insertion_sorter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import iso_pkg::*;

   typedef logic signed [DATA_WIDTH-1:0] sdata_type;

   typedef struct {
      data_type value;
      logic     last;
      logic     overflow;
   } sorted_beat_type;

   // reps > 1 sends that many random values, the final one carrying the row's last flag
   typedef struct packed {
      data_type    value;
      logic        last;
      logic [7:0]  reps;
      logic [15:0] hold;
      logic        typed;
      data_type    exp_value;
      logic        exp_last;
      logic        exp_overflow;
   } dir_row_type;

   localparam data_type VMIN = 32'h8000_0000;
   localparam data_type VMAX = 32'h7FFF_FFFF;
   localparam int NUM_ROWS     = 19;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 20;

   localparam dir_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      '{VMIN,          1'b1, 8'd1,  16'd0,   1'b1, VMIN,          1'b1, 1'b0},
      '{VMAX,          1'b1, 8'd1,  16'd0,   1'b1, VMAX,          1'b1, 1'b0},
      '{32'h0,         1'b1, 8'd1,  16'd0,   1'b1, 32'h0,         1'b1, 1'b0},
      '{32'hFFFF_FFFF, 1'b1, 8'd1,  16'd0,   1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0},
      '{VMAX,          1'b0, 8'd1,  16'd0,   1'b0, 32'h0,         1'b0, 1'b0},
      '{VMIN,          1'b0, 8'd1,  16'd0,   1'b0, 32'h0,         1'b0, 1'b0},
      '{32'hFFFF_FFFF, 1'b0, 8'd1,  16'd0,   1'b0, 32'h0,         1'b0, 1'b0},
      '{32'h0,         1'b0, 8'd1,  16'd0,   1'b0, 32'h0,         1'b0, 1'b0},
      '{32'h1,         1'b1, 8'd1,  16'd0,   1'b0, 32'h0,         1'b0, 1'b0},
      '{32'h5,         1'b0, 8'd1,  16'd0,   1'b0, 32'h0,         1'b0, 1'b0},
      '{32'h5,         1'b0, 8'd1,  16'd0,   1'b0, 32'h0,         1'b0, 1'b0},
      '{32'hFFFF_FFFB, 1'b0, 8'd1,  16'd0,   1'b0, 32'h0,         1'b0, 1'b0},
      '{32'h5,         1'b1, 8'd1,  16'd0,   1'b0, 32'h0,         1'b0, 1'b0},
      '{32'h5555_5555, 1'b0, 8'd1,  16'd0,   1'b0, 32'h0,         1'b0, 1'b0},
      '{32'hAAAA_AAAA, 1'b1, 8'd1,  16'd0,   1'b0, 32'h0,         1'b0, 1'b0},
      // exactly full, then hold the receiver while the next set is offered
      '{32'h0,         1'b0, 8'd63, 16'd0,   1'b0, 32'h0,         1'b0, 1'b0},
      '{32'hFFFF_FFFD, 1'b1, 8'd1,  16'd300, 1'b0, 32'h0,         1'b0, 1'b0},
      // full store: the last-flagged value itself is dropped
      '{32'h0,         1'b0, 8'd64, 16'd0,   1'b0, 32'h0,         1'b0, 1'b0},
      '{32'hFFFF_FFF7, 1'b1, 8'd1,  16'd0,   1'b0, 32'h0,         1'b0, 1'b0}
   };

   logic     clock;
   logic     reset;
   logic     req_tvalid;
   logic     req_tready;
   data_type req_tdata;
   logic     req_tlast;
   logic     rsp_tvalid;
   logic     rsp_tready;
   data_type rsp_tdata;
   logic     rsp_tlast;
   logic     rsp_tuser;

   sdata_type       held_values[$];
   logic            held_dropped;
   sorted_beat_type pending_sorted[$];

   int send_idle_pct;
   int rsp_idle_pct;
   int pressure_cycles;
   int error_count;
   int values_sent;
   int sets_sent;
   int overflow_sets;
   int beats_checked;
   int cycle_count;

   insertion_sorter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Append one expected sorted beat.
   function automatic void expect_beat(sorted_beat_type b);
      pending_sorted = {pending_sorted, b};
   endfunction

   // Insert after every held value not greater than v, or mark the set dropped when full; on last, release the set.
   function automatic void insert_and_release(data_type v, logic lst, logic publish);
      int pos;
      sorted_beat_type beat;
      if (held_values.size() >= MAX_ITEMS) begin
         held_dropped = 1'b1;
      end else begin
         pos = held_values.size();
         while (pos > 0 && held_values[pos-1] > sdata_type'(v))
            pos--;
         held_values.insert(pos, sdata_type'(v));
      end
      if (lst) begin
         sets_sent++;
         if (held_dropped)
            overflow_sets++;
         if (publish) begin
            foreach (held_values[k]) begin
               beat.value    = data_type'(held_values[k]);
               beat.last     = (k == held_values.size() - 1);
               beat.overflow = held_dropped;
               expect_beat(beat);
            end
         end
         held_values.delete();
         held_dropped = 1'b0;
      end
   endfunction

   function automatic data_type pick_value();
      data_type corner[6] = '{VMIN, VMAX, 32'h0, 32'hFFFF_FFFF, VMIN + 1, VMAX - 1};
      case ($urandom_range(0, 3))
         0: begin
            return data_type'($urandom_range(0, 16)) - 8;
         end
         1: begin
            return corner[$urandom_range(0, 5)];
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   // Called at a falling edge; returns at a falling edge, once a rising edge has taken the beat.
   task automatic send_beat(data_type v, logic lst, logic typed, data_type exp_v,
                            logic exp_l, logic exp_o);
      sorted_beat_type beat;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;
         req_tlast  <= 1'($urandom);
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      req_tlast  <= lst;
      do @(posedge clock); while (!req_tready);
      values_sent++;
      insert_and_release(v, lst, !typed);
      if (typed) begin
         beat.value    = exp_v;
         beat.last     = exp_l;
         beat.overflow = exp_o;
         expect_beat(beat);
      end
      @(negedge clock);
   endtask

   task automatic send_random_sets(int target);
      int size;
      while (values_sent < target) begin
         size = $urandom_range(1, 8);
         for (int i = 0; i < size; i++)
            send_beat(pick_value(), i == size - 1, 1'b0, '0, 1'b0, 1'b0);
      end
   endtask

   // Receiver: random backpressure, plus a long hold when one is requested.
   initial begin
      int hold_left;
      hold_left  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (pressure_cycles > 0) begin
            hold_left       = pressure_cycles;
            pressure_cycles = 0;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      sorted_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_sorted.size() == 0) begin
            $error("unexpected sorted beat: value %0d last %0b overflow %0b",
                   $signed(rsp_tdata), rsp_tlast, rsp_tuser);
            error_count++;
         end else begin
            want = pending_sorted.pop_front();
            beats_checked++;
            if (rsp_tdata !== want.value) begin
               $error("value_res: expected %0d, got %0d", $signed(want.value),
                      $signed(rsp_tdata));
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_res: expected %0b, got %0b", want.last, rsp_tlast);
               error_count++;
            end
            if (rsp_tuser !== want.overflow) begin
               $error("overflow: expected %0b, got %0b", want.overflow, rsp_tuser);
               error_count++;
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d sorted beats outstanding", cycle_count,
               pending_sorted.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      dir_row_type r;
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      req_tlast       = 1'b0;
      held_dropped    = 1'b0;
      pressure_cycles = 0;
      error_count     = 0;
      values_sent     = 0;
      sets_sent       = 0;
      overflow_sets   = 0;
      beats_checked   = 0;
      send_idle_pct   = 20;
      rsp_idle_pct    = 62;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < NUM_ROWS; i++) begin
         r = DIRECTED_ROWS[i];
         if (r.hold != 0)
            pressure_cycles = r.hold;
         if (r.reps > 1) begin
            for (int k = 0; k < r.reps; k++)
               send_beat(pick_value(), r.last && k == r.reps - 1, 1'b0, '0, 1'b0, 1'b0);
         end else begin
            send_beat(r.value, r.last, r.typed, r.exp_value, r.exp_last, r.exp_overflow);
         end
      end

      send_random_sets(values_sent + 6);
      send_idle_pct = 62;
      rsp_idle_pct  = 20;
      send_random_sets(values_sent + 6);
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      send_random_sets(values_sent + 6);
      req_tvalid <= 1'b0;

      while (pending_sorted.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d values in %0d sets (%0d sets overflowed the store)",
               values_sent, sets_sent, overflow_sets);
      $display("checked %0d sorted beats under three backpressure mixes and one long hold",
               beats_checked);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
